FILE: rtl/core/hatlca_pkg.sv
// ============================================================================
// hatlca_pkg: shared types and constants for the tree ancestor search
// Holds the command and status bundles that join the controller and the
// datapath, together with the fixed field widths and the empty slot code.
// ============================================================================
package hatlca_pkg;

    localparam int VALUE_W   = 32;
    localparam int OUT_IDX_W = 7;

    localparam logic [VALUE_W-1:0] EMPTY_SLOT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic load;
        logic start;
        logic rd_node;
        logic eval;
        logic fetch;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cursor_zero;
    } sts_t;

endpackage

FILE: rtl/core/hatlca_dp.sv
// ============================================================================
// hatlca_dp: datapath of the tree ancestor search
// Stores the loaded node values and the per-node partial results, walks the
// nodes from the highest index down to the root and holds the output fields.
// ============================================================================
module hatlca_dp #(
    parameter int MAX_NODES = 128
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  hatlca_pkg::cmd_t                        cmd,
    output hatlca_pkg::sts_t                        sts,
    input  logic signed [hatlca_pkg::VALUE_W-1:0]   node_value,
    input  logic signed [hatlca_pkg::VALUE_W-1:0]   key_a,
    input  logic signed [hatlca_pkg::VALUE_W-1:0]   key_b,
    output logic                                    found,
    output logic signed [hatlca_pkg::VALUE_W-1:0]   ancestor_value,
    output logic [hatlca_pkg::OUT_IDX_W-1:0]        ancestor_index,
    output logic                                    overflow
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int CMP_W = IDX_W + 2;

    logic [hatlca_pkg::VALUE_W-1:0] value_mem [MAX_NODES];
    logic [IDX_W:0]                 part_mem  [MAX_NODES];

    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic                           ovf_reg;
    logic                           ovf_next;
    logic [IDX_W-1:0]               cursor_reg;
    logic [IDX_W-1:0]               cursor_next;
    logic [hatlca_pkg::VALUE_W-1:0] key_a_reg;
    logic [hatlca_pkg::VALUE_W-1:0] key_b_reg;
    logic                           res_valid_reg;
    logic [IDX_W-1:0]               res_idx_reg;

    logic [hatlca_pkg::VALUE_W-1:0] value_rd_reg;
    logic [IDX_W:0]                 part_l_reg;
    logic [IDX_W:0]                 part_r_reg;
    logic [IDX_W-1:0]               value_addr;

    logic                           found_reg;
    logic [hatlca_pkg::VALUE_W-1:0] ancestor_value_reg;
    logic [hatlca_pkg::OUT_IDX_W-1:0] ancestor_index_reg;
    logic                           overflow_reg;

    logic                           full;
    logic [IDX_W:0]                 left_idx;
    logic [CMP_W-1:0]               right_idx;
    logic                           left_in;
    logic                           right_in;
    logic                           lv;
    logic                           rv;
    logic                           is_empty;
    logic                           is_key;
    logic                           node_valid;
    logic [IDX_W-1:0]               node_idx;
    logic [IDX_W+hatlca_pkg::OUT_IDX_W-1:0] idx_ext;

    assign full      = (count_reg == CNT_W'(MAX_NODES));
    assign left_idx  = {cursor_reg, 1'b1};
    assign right_idx = {1'b0, cursor_reg, 1'b0} + CMP_W'(2);
    assign left_in   = (CMP_W'(left_idx) < CMP_W'(count_reg));
    assign right_in  = (right_idx < CMP_W'(count_reg));
    assign lv        = left_in & part_l_reg[IDX_W];
    assign rv        = right_in & part_r_reg[IDX_W];
    assign is_empty  = (value_rd_reg == hatlca_pkg::EMPTY_SLOT);
    assign is_key    = (value_rd_reg == key_a_reg) || (value_rd_reg == key_b_reg);
    assign value_addr = cmd.fetch ? res_idx_reg : cursor_reg;
    assign sts.cursor_zero = (cursor_reg == '0);

    always_comb
    begin
        node_valid = 1'b0;
        node_idx   = '0;
        if (!is_empty)
        begin
            if (is_key || (lv && rv))
            begin
                node_valid = 1'b1;
                node_idx   = cursor_reg;
            end
            else if (lv)
            begin
                node_valid = 1'b1;
                node_idx   = part_l_reg[IDX_W-1:0];
            end
            else if (rv)
            begin
                node_valid = 1'b1;
                node_idx   = part_r_reg[IDX_W-1:0];
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        cursor_next = cursor_reg;
        if (cmd.load)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.start)
        begin
            cursor_next = full ? IDX_W'(MAX_NODES - 1) : count_reg[IDX_W-1:0];
        end
        if (cmd.eval && !sts.cursor_zero)
        begin
            cursor_next = cursor_reg - IDX_W'(1);
        end
        if (cmd.out_load)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        if (cmd.start)
        begin
            key_a_reg <= key_a;
            key_b_reg <= key_b;
        end
        if (cmd.eval && sts.cursor_zero)
        begin
            res_valid_reg <= node_valid;
            res_idx_reg   <= node_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            value_mem[count_reg[IDX_W-1:0]] <= node_value;
        end
        if (cmd.rd_node || cmd.fetch)
        begin
            value_rd_reg <= value_mem[value_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            part_mem[cursor_reg] <= {node_valid, node_idx};
        end
        if (cmd.rd_node)
        begin
            part_l_reg <= part_mem[left_idx[IDX_W-1:0]];
            part_r_reg <= part_mem[right_idx[IDX_W-1:0]];
        end
    end

    assign idx_ext = {{hatlca_pkg::OUT_IDX_W{1'b0}}, res_idx_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            found_reg          <= res_valid_reg;
            ancestor_value_reg <= res_valid_reg ? value_rd_reg : '0;
            ancestor_index_reg <= res_valid_reg ? idx_ext[hatlca_pkg::OUT_IDX_W-1:0] : '0;
            overflow_reg       <= ovf_reg;
        end
    end

    assign found          = found_reg;
    assign ancestor_value = ancestor_value_reg;
    assign ancestor_index = ancestor_index_reg;
    assign overflow       = overflow_reg;

endmodule

FILE: rtl/core/hatlca_ctrl.sv
// ============================================================================
// hatlca_ctrl: controller of the tree ancestor search
// Sequences loading, the bottom-up pass, the ancestor value fetch and the
// hand-over to the output register, and owns both handshakes.
// ============================================================================
module hatlca_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             last,
    output logic             out_valid,
    input  logic             out_stall,
    output hatlca_pkg::cmd_t cmd,
    input  hatlca_pkg::sts_t sts
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_stall  = (state_reg != S_LOAD);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !(out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = accept;
        cmd.start    = accept && last;
        cmd.rd_node  = (state_reg == S_READ);
        cmd.eval     = (state_reg == S_EVAL);
        cmd.fetch    = (state_reg == S_FETCH);
        cmd.out_load = (state_reg == S_DONE) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept && last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = sts.cursor_zero ? S_FETCH : S_READ;
            end
            S_FETCH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The final node of a tree always starts the pass.
    a_last_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> state_reg == S_READ)
        else $error("last beat did not start the pass");

    // Every node but the root is followed by a read of the next lower node.
    a_pass_continues: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL && !sts.cursor_zero |=> state_reg == S_READ)
        else $error("pass ended before the root");

    // A finished result waits while the previous one is still held.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid_reg && out_stall |=> state_reg == S_DONE)
        else $error("result overwrote a stalled beat");

    // A result only appears at the end of a search.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the done state");

endmodule

FILE: rtl/core/heap_array_tree_lca_top.sv
// ============================================================================
// heap_array_tree_lca_top: lowest common ancestor in a level-order tree
// Loads node values one beat at a time and, on the beat flagged last, finds
// the lowest common ancestor of the two keys carried by that beat.
// ============================================================================
// Usage: the input channel carries one node per beat in level order, with
// -1 marking an empty slot that cuts off its subtree. Loading takes one beat
// per cycle while in_stall is low. The beat with last set is also a node, and
// its keys start the search; nodes beyond MAX_NODES are dropped and set the
// overflow flag. The search walks the stored nodes from the highest index to
// the root; for each node it does a memory read, then the merge of the
// children's results, as the store reads are registered and a child may be
// merged just before. While the search runs, in_stall stays high throughout.
// Each search gives exactly one result beat.
// The result sits in an output register; loading of the next tree may start
// while it waits, but a further search holds in its final step until the
// receiver has taken the earlier beat. Reset empties the tree, clears the
// overflow flag and drops any result not yet taken; the stores need no
// clearing pass.
// ============================================================================
module heap_array_tree_lca_top #(
    parameter int MAX_NODES = 128
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [hatlca_pkg::VALUE_W-1:0]   node_value,
    input  logic signed [hatlca_pkg::VALUE_W-1:0]   key_a,
    input  logic signed [hatlca_pkg::VALUE_W-1:0]   key_b,
    input  logic                                    last,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    found,
    output logic signed [hatlca_pkg::VALUE_W-1:0]   ancestor_value,
    output logic [hatlca_pkg::OUT_IDX_W-1:0]        ancestor_index,
    output logic                                    overflow
);

    hatlca_pkg::cmd_t cmd;
    hatlca_pkg::sts_t sts;

    hatlca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    hatlca_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .node_value     (node_value),
        .key_a          (key_a),
        .key_b          (key_b),
        .found          (found),
        .ancestor_value (ancestor_value),
        .ancestor_index (ancestor_index),
        .overflow       (overflow)
    );

endmodule
